// ===== sv/rk4p_pkg.sv =====
`timescale 1ns / 1ps

package rk4p_pkg;

    // Fixed field widths
    localparam int STEP_BITS      = 21;
    localparam int CFG_BITS       = 32;
    localparam int OUT_BITS       = 32;
    localparam int CFG_INDEX_BITS = 2;

    // The multiplier takes the low MUL_SPLIT operand bits first, then the rest.
    localparam int MUL_SPLIT = 24;

    // Quotient bits produced per cycle by the divide-by-three unit.
    localparam int DIG_BITS = 16;

    // Configuration register indexes
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t REG_STEP_SIZE = 2'd0;
    localparam cfg_index_t REG_START_X   = 2'd1;
    localparam cfg_index_t REG_START_Y0  = 2'd2;
    localparam cfg_index_t REG_START_Y1  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [STEP_BITS-1:0]       RST_STEP_SIZE = 21'd52429;
    localparam logic signed [CFG_BITS-1:0] RST_START_X   = -32'sd524288;
    localparam logic signed [CFG_BITS-1:0] RST_START_Y0  = 32'sd4068499;
    localparam logic signed [CFG_BITS-1:0] RST_START_Y1  = 32'sd2196748;

    // Datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NONE     = 4'd0;
    localparam op_t OP_LOAD     = 4'd1;
    localparam op_t OP_INIT     = 4'd2;
    localparam op_t OP_DERIV    = 4'd3;
    localparam op_t OP_MUL_LO   = 4'd4;
    localparam op_t OP_MUL_HI   = 4'd5;
    localparam op_t OP_MUL_SUM  = 4'd6;
    localparam op_t OP_STAGE    = 4'd7;
    localparam op_t OP_DIV_LOAD = 4'd8;
    localparam op_t OP_DIV_STEP = 4'd9;
    localparam op_t OP_UPDATE   = 4'd10;
    localparam op_t OP_EMIT     = 4'd11;

    // Multiplier operand select
    typedef logic [1:0] opnd_t;
    localparam opnd_t OPND_KA = 2'd0;
    localparam opnd_t OPND_KB = 2'd1;
    localparam opnd_t OPND_SA = 2'd2;
    localparam opnd_t OPND_SB = 2'd3;

    // Abscissa select for a derivative evaluation
    typedef logic [1:0] xsel_t;
    localparam xsel_t XSEL_X   = 2'd0;
    localparam xsel_t XSEL_MID = 2'd1;
    localparam xsel_t XSEL_END = 2'd2;

    // Command from the controller to the datapath
    typedef struct packed {
        op_t   op;
        opnd_t opnd;
        xsel_t xsel;
        logic  dbl;   // weight the derivative by two in the running sum
        logic  half;  // stage value uses k*h/2 instead of k*h
        logic  lane;  // 0 for the first unknown, 1 for the second
    } cmd_t;

endpackage

// ===== sv/rk4p_datapath.sv =====
`timescale 1ns / 1ps

module rk4p_datapath #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  rk4p_pkg::cfg_index_t                 cfg_index,
    input  logic [rk4p_pkg::CFG_BITS-1:0]        cfg_data,
    input  rk4p_pkg::cmd_t                       cmd,
    output logic signed [rk4p_pkg::OUT_BITS-1:0] point_x,
    output logic signed [rk4p_pkg::OUT_BITS-1:0] point_y0,
    output logic signed [rk4p_pkg::OUT_BITS-1:0] point_y1,
    output logic                                 saturated
);

    localparam int W    = WORD_BITS;
    localparam int SB   = rk4p_pkg::STEP_BITS;
    localparam int MS   = rk4p_pkg::MUL_SPLIT;
    localparam int DB   = rk4p_pkg::DIG_BITS;
    localparam int SW   = W + 3;                    // weighted sum of six derivatives
    localparam int PW   = SW + SB;                  // full product width
    localparam int HIW  = SW - MS;                  // upper operand part
    localparam int LPW  = MS + SB;                  // low partial product
    localparam int HPW  = HIW + SB + 1;             // high partial product
    localparam int SATW = PW + 2;                   // common width before clamping
    localparam int DPW  = ((PW + DB - 1) / DB) * DB;
    localparam int EXTW = (W > rk4p_pkg::OUT_BITS) ? W : rk4p_pkg::OUT_BITS;
    localparam int NIBS = DB / 4;

    localparam logic signed [SATW-1:0] SAT_HI  = {{(SATW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SATW-1:0] SAT_LO  = ~SAT_HI;
    localparam logic signed [SATW-1:0] ONE_EXT =
        {{(SATW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    // Clamp to the word; the top bit of the result is the clip flag.
    function automatic logic [W:0] sat_w(input logic signed [SATW-1:0] v);
        logic [W:0] res;
        if (v > SAT_HI)
            res = {1'b1, 1'b0, {(W-1){1'b1}}};
        else if (v < SAT_LO)
            res = {1'b1, 1'b1, {(W-1){1'b0}}};
        else
            res = {1'b0, v[W-1:0]};
        return res;
    endfunction

    // One radix-16 digit of a divide by three: {quotient digit, remainder}.
    function automatic logic [5:0] div3_digit(input logic [1:0] r, input logic [3:0] n);
        logic [5:0]  v;
        logic [11:0] p;
        logic [3:0]  q;
        logic [5:0]  rr;
        v  = {r, n};
        p  = 12'(v) * 12'd43;
        q  = p[10:7];
        rr = v - ({2'b00, q} + {1'b0, q, 1'b0});
        return {q, rr[1:0]};
    endfunction

    // Configuration and integration state
    logic        [SB-1:0]                 step_reg;
    logic signed [rk4p_pkg::CFG_BITS-1:0] start_x_reg, start_y0_reg, start_y1_reg;
    logic signed [W-1:0]                  x_reg, y0_reg, y1_reg;

    // Working registers
    logic signed [W-1:0]  xm_reg, xe_reg, ya_reg, yb_reg, ka_reg, kb_reg;
    logic signed [SW-1:0] sa_reg, sb_reg;
    logic signed [PW-1:0] mp_reg, acc_reg;
    logic        [DPW-1:0] dvd_reg, quo_reg;
    logic        [1:0]    rem_reg;
    logic                 neg_reg, flag_reg;
    logic signed [rk4p_pkg::OUT_BITS-1:0] out_x_reg, out_y0_reg, out_y1_reg;
    logic                 out_sat_reg;

    // Combinational results
    logic [W:0]            lx_s, ly0_s, ly1_s, xm_s, xe_s, d0_s, d1_s, stg_s, upd_s;
    logic signed [W-1:0]   xs, ysel;
    logic signed [SATW-1:0] xs_e, ya_e, yb_e, d0_raw, d1_raw, stg_raw, upd_raw;
    logic signed [SW-1:0]  ka_w, kb_w, opnd_val;
    logic        [MS-1:0]  lo_part;
    logic signed [HIW-1:0] hi_part;
    logic        [LPW-1:0] lo_prod;
    logic signed [HPW-1:0] hi_prod;
    logic signed [PW-1:0]  stg_t, div_q, div_d;
    logic        [DPW-1:0] div_u;
    logic        [DB-1:0]  q_chunk;
    logic        [1:0]     r_tmp;
    logic        [5:0]     dig;
    logic signed [EXTW-1:0] ext_x, ext_y0, ext_y1;

    // Restart values and abscissas of the midpoint and end of the step
    always_comb
    begin
        lx_s  = sat_w(SATW'(start_x_reg));
        ly0_s = sat_w(SATW'(start_y0_reg));
        ly1_s = sat_w(SATW'(start_y1_reg));
        xm_s  = sat_w(SATW'(x_reg) + SATW'({1'b0, step_reg[SB-1:1]}));
        xe_s  = sat_w(SATW'(x_reg) + SATW'({1'b0, step_reg}));
    end

    // Derivative evaluation at the selected stage point
    always_comb
    begin
        unique case (cmd.xsel)
            rk4p_pkg::XSEL_X:   xs = x_reg;
            rk4p_pkg::XSEL_MID: xs = xm_reg;
            rk4p_pkg::XSEL_END: xs = xe_reg;
            default:            xs = x_reg;
        endcase
        xs_e   = SATW'(xs);
        ya_e   = SATW'(ya_reg);
        yb_e   = SATW'(yb_reg);
        d0_raw = -ONE_EXT - (xs_e <<< 2) + (ya_e <<< 2) - ((yb_e <<< 2) + yb_e);
        d1_raw = xs_e + ya_e - (yb_e <<< 1);
        d0_s   = sat_w(d0_raw);
        d1_s   = sat_w(d1_raw);
        ka_w   = SW'($signed(d0_s[W-1:0]));
        kb_w   = SW'($signed(d1_s[W-1:0]));
    end

    // Shared multiplier: operand times h in two partial products
    always_comb
    begin
        unique case (cmd.opnd)
            rk4p_pkg::OPND_KA: opnd_val = SW'(ka_reg);
            rk4p_pkg::OPND_KB: opnd_val = SW'(kb_reg);
            rk4p_pkg::OPND_SA: opnd_val = sa_reg;
            rk4p_pkg::OPND_SB: opnd_val = sb_reg;
            default:           opnd_val = sa_reg;
        endcase
        lo_part = opnd_val[MS-1:0];
        hi_part = opnd_val[SW-1:MS];
        lo_prod = LPW'(lo_part) * LPW'(step_reg);
        hi_prod = HPW'(hi_part) * HPW'($signed({1'b0, step_reg}));
    end

    // Stage value y + k*h (or k*h/2), floor of the scaled product
    always_comb
    begin
        ysel    = cmd.lane ? y1_reg : y0_reg;
        stg_t   = cmd.half ? (acc_reg >>> (FRAC_BITS + 1)) : (acc_reg >>> FRAC_BITS);
        stg_raw = SATW'(ysel) + SATW'(stg_t);
        stg_s   = sat_w(stg_raw);
    end

    // Divide by six: halve by shifting, then divide the magnitude code by three.
    // The remainder carries from one digit cycle to the next.
    always_comb
    begin
        div_q = acc_reg >>> (FRAC_BITS + 1);
        div_u = DPW'($unsigned(div_q[PW-1] ? ~div_q : div_q));
        r_tmp = rem_reg;
        q_chunk = '0;
        for (int i = 0; i < NIBS; i++)
        begin
            dig = div3_digit(r_tmp, dvd_reg[DPW-1-4*i -: 4]);
            q_chunk[DB-1-4*i -: 4] = dig[5:2];
            r_tmp = dig[1:0];
        end
        div_d   = neg_reg ? ~$signed(quo_reg[PW-1:0]) : $signed(quo_reg[PW-1:0]);
        upd_raw = SATW'(ysel) + SATW'(div_d);
        upd_s   = sat_w(upd_raw);
    end

    // Result fields are the low bits of the sign-extended word
    always_comb
    begin
        ext_x  = EXTW'(x_reg);
        ext_y0 = EXTW'(y0_reg);
        ext_y1 = EXTW'(y1_reg);
    end

    // Configuration registers and the integration point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= rk4p_pkg::RST_STEP_SIZE;
            start_x_reg  <= rk4p_pkg::RST_START_X;
            start_y0_reg <= rk4p_pkg::RST_START_Y0;
            start_y1_reg <= rk4p_pkg::RST_START_Y1;
            x_reg        <= W'(sat_w(SATW'(rk4p_pkg::RST_START_X)));
            y0_reg       <= W'(sat_w(SATW'(rk4p_pkg::RST_START_Y0)));
            y1_reg       <= W'(sat_w(SATW'(rk4p_pkg::RST_START_Y1)));
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    rk4p_pkg::REG_STEP_SIZE: step_reg     <= cfg_data[SB-1:0];
                    rk4p_pkg::REG_START_X:   start_x_reg  <= cfg_data;
                    rk4p_pkg::REG_START_Y0:  start_y0_reg <= cfg_data;
                    rk4p_pkg::REG_START_Y1:  start_y1_reg <= cfg_data;
                    default:                 step_reg     <= step_reg;
                endcase
            end
            if (cmd.op == rk4p_pkg::OP_LOAD)
            begin
                x_reg  <= lx_s[W-1:0];
                y0_reg <= ly0_s[W-1:0];
                y1_reg <= ly1_s[W-1:0];
            end
            else if (cmd.op == rk4p_pkg::OP_UPDATE)
            begin
                if (cmd.lane)
                begin
                    y1_reg <= upd_s[W-1:0];
                    x_reg  <= xe_reg;
                end
                else
                begin
                    y0_reg <= upd_s[W-1:0];
                end
            end
        end
    end

    // Working registers, driven by the controller's command
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            rk4p_pkg::OP_LOAD:
            begin
                flag_reg <= lx_s[W] | ly0_s[W] | ly1_s[W];
            end
            rk4p_pkg::OP_INIT:
            begin
                xm_reg   <= xm_s[W-1:0];
                xe_reg   <= xe_s[W-1:0];
                ya_reg   <= y0_reg;
                yb_reg   <= y1_reg;
                sa_reg   <= '0;
                sb_reg   <= '0;
                flag_reg <= xm_s[W] | xe_s[W];
            end
            rk4p_pkg::OP_DERIV:
            begin
                ka_reg   <= d0_s[W-1:0];
                kb_reg   <= d1_s[W-1:0];
                sa_reg   <= sa_reg + (cmd.dbl ? (ka_w <<< 1) : ka_w);
                sb_reg   <= sb_reg + (cmd.dbl ? (kb_w <<< 1) : kb_w);
                flag_reg <= flag_reg | d0_s[W] | d1_s[W];
            end
            rk4p_pkg::OP_MUL_LO:
            begin
                mp_reg <= PW'(lo_prod);
            end
            rk4p_pkg::OP_MUL_HI:
            begin
                acc_reg <= mp_reg;
                mp_reg  <= PW'(hi_prod);
            end
            rk4p_pkg::OP_MUL_SUM:
            begin
                acc_reg <= acc_reg + (mp_reg <<< MS);
            end
            rk4p_pkg::OP_STAGE:
            begin
                if (cmd.lane)
                    yb_reg <= stg_s[W-1:0];
                else
                    ya_reg <= stg_s[W-1:0];
                flag_reg <= flag_reg | stg_s[W];
            end
            rk4p_pkg::OP_DIV_LOAD:
            begin
                dvd_reg <= div_u;
                quo_reg <= '0;
                rem_reg <= 2'b00;
                neg_reg <= div_q[PW-1];
            end
            rk4p_pkg::OP_DIV_STEP:
            begin
                dvd_reg <= dvd_reg << DB;
                quo_reg <= {quo_reg[DPW-DB-1:0], q_chunk};
                rem_reg <= r_tmp;
            end
            rk4p_pkg::OP_UPDATE:
            begin
                flag_reg <= flag_reg | upd_s[W];
            end
            rk4p_pkg::OP_EMIT:
            begin
                out_x_reg   <= ext_x[rk4p_pkg::OUT_BITS-1:0];
                out_y0_reg  <= ext_y0[rk4p_pkg::OUT_BITS-1:0];
                out_y1_reg  <= ext_y1[rk4p_pkg::OUT_BITS-1:0];
                out_sat_reg <= flag_reg;
            end
            default:
            begin
                flag_reg <= flag_reg;
            end
        endcase
    end

    assign point_x   = out_x_reg;
    assign point_y0  = out_y0_reg;
    assign point_y1  = out_y1_reg;
    assign saturated = out_sat_reg;

endmodule

// ===== sv/rk4p_ctrl.sv =====
`timescale 1ns / 1ps

module rk4p_ctrl #(
    parameter int DIV_STEPS = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_restart,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output rk4p_pkg::cmd_t cmd
);

    localparam int CW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_INIT  = 4'd2;
    localparam logic [3:0] ST_DERIV = 4'd3;
    localparam logic [3:0] ST_MLO   = 4'd4;
    localparam logic [3:0] ST_MHI   = 4'd5;
    localparam logic [3:0] ST_MSUM  = 4'd6;
    localparam logic [3:0] ST_STAGE = 4'd7;
    localparam logic [3:0] ST_DLOAD = 4'd8;
    localparam logic [3:0] ST_DSTEP = 4'd9;
    localparam logic [3:0] ST_UPD   = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    stage_reg, stage_next;
    logic          lane_reg, lane_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          last_stage;
    logic          out_free;

    assign last_stage = (stage_reg == 2'd3);
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;

    // Sequencer: command for this cycle and next state
    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        lane_next  = lane_reg;
        cnt_next   = cnt_reg;
        cmd.op     = rk4p_pkg::OP_NONE;
        cmd.opnd   = lane_reg ? rk4p_pkg::OPND_KB : rk4p_pkg::OPND_KA;
        cmd.xsel   = rk4p_pkg::XSEL_X;
        cmd.dbl    = (stage_reg == 2'd1) || (stage_reg == 2'd2);
        cmd.half   = (stage_reg != 2'd2);
        cmd.lane   = lane_reg;
        if (last_stage)
            cmd.opnd = lane_reg ? rk4p_pkg::OPND_SB : rk4p_pkg::OPND_SA;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = in_restart ? ST_LOAD : ST_INIT;
            end
            ST_LOAD:
            begin
                cmd.op     = rk4p_pkg::OP_LOAD;
                state_next = ST_FIN;
            end
            ST_INIT:
            begin
                cmd.op     = rk4p_pkg::OP_INIT;
                stage_next = 2'd0;
                lane_next  = 1'b0;
                state_next = ST_DERIV;
            end
            ST_DERIV:
            begin
                cmd.op = rk4p_pkg::OP_DERIV;
                if (stage_reg == 2'd0)
                    cmd.xsel = rk4p_pkg::XSEL_X;
                else if (last_stage)
                    cmd.xsel = rk4p_pkg::XSEL_END;
                else
                    cmd.xsel = rk4p_pkg::XSEL_MID;
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                cmd.op     = rk4p_pkg::OP_MUL_LO;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.op     = rk4p_pkg::OP_MUL_HI;
                state_next = ST_MSUM;
            end
            ST_MSUM:
            begin
                cmd.op     = rk4p_pkg::OP_MUL_SUM;
                state_next = last_stage ? ST_DLOAD : ST_STAGE;
            end
            ST_STAGE:
            begin
                cmd.op = rk4p_pkg::OP_STAGE;
                if (!lane_reg)
                begin
                    lane_next  = 1'b1;
                    state_next = ST_MLO;
                end
                else
                begin
                    lane_next  = 1'b0;
                    stage_next = stage_reg + 2'd1;
                    state_next = ST_DERIV;
                end
            end
            ST_DLOAD:
            begin
                cmd.op     = rk4p_pkg::OP_DIV_LOAD;
                cnt_next   = CW'(DIV_STEPS - 1);
                state_next = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                cmd.op = rk4p_pkg::OP_DIV_STEP;
                if (cnt_reg == '0)
                    state_next = ST_UPD;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_UPD:
            begin
                cmd.op = rk4p_pkg::OP_UPDATE;
                if (!lane_reg)
                begin
                    lane_next  = 1'b1;
                    state_next = ST_MLO;
                end
                else
                begin
                    lane_next  = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.op     = rk4p_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag: set when a result is loaded, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == rk4p_pkg::OP_EMIT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stage_reg     <= 2'd0;
            lane_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            lane_reg      <= lane_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The datapath stays quiet while the block waits for a request.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cmd.op == rk4p_pkg::OP_NONE))
        else $error("datapath command issued while idle");

    // A result is never loaded over one that has not been taken.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == rk4p_pkg::OP_EMIT) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    // An accepted request starts either a reload or a step.
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_LOAD || state_reg == ST_INIT))
        else $error("accepted request did not start");

    // The divide counter stays within the number of digit cycles.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DSTEP) |-> (cnt_reg <= CW'(DIV_STEPS - 1)))
        else $error("divide counter out of range");
`endif

endmodule

// ===== sv/rk4_linear_ode_pair_stepper.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Signals                    Contents
// s_*       in         s_tvalid s_tready s_tdata  request: restart at bit 0
// m_*       out        m_tvalid m_tready m_tdata  result: x, y0, y1, saturated
// cfg_*     in         cfg_wr_en cfg_index cfg_data  register writes, no read-back
//
// A restart request loads the point from the start registers, then the result into the
// output register. A step request runs the four derivative stages through the single
// shared multiplier; for each unknown the divide-by-three unit then takes D digit steps
// of 16 bits each (D = 4 at the default word size) before the result is loaded.
// A new request is accepted once the previous result is loaded into the output
// register, so the next item runs while a finished result waits on m_tready.
// Reset loads the start registers with their defaults and the point with the start.
module rk4_linear_ode_pair_stepper #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 20
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,   // [0] restart, [7:1] zero
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [31:0] point_x, [63:32] point_y0, [95:64] point_y1, [96] saturated, [103:97] zero
    output logic [103:0]                           m_tdata,
    input  logic                                   cfg_wr_en,
    input  rk4p_pkg::cfg_index_t                   cfg_index,
    input  logic [rk4p_pkg::CFG_BITS-1:0]          cfg_data
);

    localparam int PW        = WORD_BITS + 3 + rk4p_pkg::STEP_BITS;
    localparam int DIV_STEPS = (PW + rk4p_pkg::DIG_BITS - 1) / rk4p_pkg::DIG_BITS;

    rk4p_pkg::cmd_t                       cmd;
    logic signed [rk4p_pkg::OUT_BITS-1:0] point_x, point_y0, point_y1;
    logic                                 saturated;

    // Sequencer
    rk4p_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_restart (s_tdata[0]),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .cmd        (cmd)
    );

    // Arithmetic, state and output register
    rk4p_datapath #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .point_x   (point_x),
        .point_y0  (point_y0),
        .point_y1  (point_y1),
        .saturated (saturated)
    );

    // Result packing, first field in the lowest bits
    assign m_tdata = {7'b0, saturated, point_y1, point_y0, point_x};

endmodule
